// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro has a checking form and an empty form for synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks a property on every rising clock edge outside of reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checks that an expression is true on every rising clock edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, rst, expr)
`endif
`endif

// File: rtl/ipqc_pkg.sv
package ipqc_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 8;

  localparam logic [2:0] OP_REQUEST   = 3'd0;
  localparam logic [2:0] OP_TAKE      = 3'd1;
  localparam logic [2:0] OP_ENABLE    = 3'd2;
  localparam logic [2:0] OP_DISABLE   = 3'd3;
  localparam logic [2:0] OP_CSR_READ  = 3'd4;
  localparam logic [2:0] OP_CSR_WRITE = 3'd5;
  localparam logic [2:0] OP_TICK      = 3'd6;

  localparam logic [1:0] KIND_EXTERNAL = 2'd2;
  localparam logic [1:0] KIND_INVALID  = 2'd3;

  localparam logic [11:0] CSR_MSTATUS = 12'h300;
  localparam logic [11:0] CSR_MIE     = 12'h304;
  localparam logic [11:0] CSR_MIP     = 12'h344;
  localparam logic [11:0] CSR_MCAUSE  = 12'h342;

  localparam int MIE_BIT_POS = 3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  irq_kind;
    logic [31:0] irq_origin;
    logic [11:0] csr_address;
    logic [31:0] csr_value;
  } request_t;

  typedef struct packed {
    logic        taken;
    logic [1:0]  taken_kind;
    logic [31:0] taken_origin;
    logic [31:0] taken_stamp;
    logic [31:0] read_data;
    logic        any_pending;
    logic [2:0]  kinds_live;
    logic        dropped;
  } result_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic latch;   // capture the incoming item
    logic exec;    // carry out the latched operation, clear the result
    logic fetch;   // read the queue memory
    logic pop;     // retire the entry whose read data is valid
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic take_go; // latched take is served and the queue holds entries
    logic hit;     // fetched entry has an enabled kind
    logic more;    // more than one entry is queued
  } status_t;

endpackage

// File: rtl/ipqc_datapath.sv
`include "assert_macros.svh"

module ipqc_datapath #(
  parameter int QUEUE_DEPTH = ipqc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  ipqc_pkg::cmd_t    cmd,
  input  ipqc_pkg::request_t request,
  output ipqc_pkg::status_t status,
  output ipqc_pkg::result_t result
);

  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] origin;
    logic [31:0] stamp;
  } entry_t;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_entry;

  ipqc_pkg::request_t req;

  logic [HW-1:0] queue_head;
  logic [CW-1:0] queue_count;
  logic          external_held;
  logic [2:0]    kind_enables;
  logic          global_enable;
  logic          status_enable;
  logic [31:0]   status_other_bits;
  logic [31:0]   enable_register;
  logic [31:0]   pending_register;
  logic [31:0]   cycle_counter;

  logic          res_taken;
  logic [1:0]    res_kind;
  logic [31:0]   res_origin;
  logic [31:0]   res_stamp;
  logic          res_have_stamp;
  logic [31:0]   res_rdata;
  logic          res_dropped;

  logic [SW-1:0] tail_sum;
  logic [HW-1:0] tail;
  logic [HW-1:0] head_inc;
  logic [HW-1:0] rd_addr;
  logic          gates;
  logic [3:0]    enables4;
  logic          kind_ok;

  assign gates    = global_enable && status_enable;
  assign enables4 = {1'b0, kind_enables};
  assign kind_ok  = req.irq_kind != ipqc_pkg::KIND_INVALID;

  assign tail_sum = SW'(queue_head) + SW'(queue_count);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : HW'(tail_sum);
  assign head_inc = (queue_head == HW'(QUEUE_DEPTH - 1)) ? '0 : queue_head + 1'b1;
  assign rd_addr  = cmd.pop ? head_inc : queue_head;

  assign status.take_go = (req.operation == ipqc_pkg::OP_TAKE) && gates
                          && (queue_count != '0);
  assign status.hit     = enables4[rd_entry.kind];
  assign status.more    = queue_count > CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= request;
    end
  end

  // Queue storage: one write port at the tail, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.exec && req.operation == ipqc_pkg::OP_REQUEST && kind_ok
        && !(req.irq_kind == ipqc_pkg::KIND_EXTERNAL && external_held)
        && queue_count != CW'(QUEUE_DEPTH)) begin
      mem[tail] <= '{kind: req.irq_kind, origin: req.irq_origin, stamp: cycle_counter};
    end
    if (cmd.fetch) begin
      rd_entry <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head        <= '0;
      queue_count       <= '0;
      external_held     <= 1'b0;
      kind_enables      <= '0;
      global_enable     <= 1'b0;
      status_enable     <= 1'b0;
      status_other_bits <= '0;
      enable_register   <= '0;
      pending_register  <= '0;
      cycle_counter     <= '0;
    end else if (cmd.exec) begin
      unique case (req.operation)
        ipqc_pkg::OP_REQUEST: begin
          if (kind_ok && !(req.irq_kind == ipqc_pkg::KIND_EXTERNAL && external_held)
              && queue_count != CW'(QUEUE_DEPTH)) begin
            queue_count      <= queue_count + 1'b1;
            pending_register <= pending_register | (32'd1 << req.irq_kind);
            if (req.irq_kind == ipqc_pkg::KIND_EXTERNAL) begin
              external_held <= 1'b1;
            end
          end
        end
        ipqc_pkg::OP_ENABLE: begin
          if (kind_ok) begin
            kind_enables    <= kind_enables | (3'd1 << req.irq_kind);
            enable_register <= enable_register | (32'd1 << req.irq_kind);
          end
        end
        ipqc_pkg::OP_DISABLE: begin
          if (kind_ok) begin
            kind_enables    <= kind_enables & ~(3'd1 << req.irq_kind);
            enable_register <= enable_register & ~(32'd1 << req.irq_kind);
          end
        end
        ipqc_pkg::OP_CSR_WRITE: begin
          unique case (req.csr_address)
            ipqc_pkg::CSR_MSTATUS: begin
              status_enable     <= req.csr_value[ipqc_pkg::MIE_BIT_POS];
              status_other_bits <= req.csr_value & ~(32'd1 << ipqc_pkg::MIE_BIT_POS);
            end
            ipqc_pkg::CSR_MIE: begin
              enable_register <= req.csr_value;
              global_enable   <= req.csr_value[ipqc_pkg::MIE_BIT_POS];
            end
            ipqc_pkg::CSR_MIP: begin
              pending_register <= req.csr_value;
            end
            default: begin
            end
          endcase
        end
        ipqc_pkg::OP_TICK: begin
          cycle_counter <= cycle_counter + 32'd1;
        end
        default: begin
        end
      endcase
    end else if (cmd.pop) begin
      queue_head  <= head_inc;
      queue_count <= queue_count - 1'b1;
      if (rd_entry.kind == ipqc_pkg::KIND_EXTERNAL) begin
        external_held <= 1'b0;
      end
      if (status.hit) begin
        pending_register <= pending_register & ~(32'd1 << rd_entry.kind);
      end
    end
  end

  // Result fields of the item in flight.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_taken      <= 1'b0;
      res_kind       <= '0;
      res_origin     <= '0;
      res_stamp      <= '0;
      res_have_stamp <= 1'b0;
      res_dropped    <= 1'b0;
      res_rdata      <= '0;
      if (req.operation == ipqc_pkg::OP_REQUEST && kind_ok
          && !(req.irq_kind == ipqc_pkg::KIND_EXTERNAL && external_held)
          && queue_count == CW'(QUEUE_DEPTH)) begin
        res_dropped <= 1'b1;
      end
      if (req.operation == ipqc_pkg::OP_CSR_READ) begin
        unique case (req.csr_address)
          ipqc_pkg::CSR_MSTATUS:
            res_rdata <= status_other_bits | (32'(status_enable) << ipqc_pkg::MIE_BIT_POS);
          ipqc_pkg::CSR_MIE:    res_rdata <= enable_register;
          ipqc_pkg::CSR_MIP:    res_rdata <= pending_register;
          ipqc_pkg::CSR_MCAUSE: res_rdata <= '0;
          default:              res_rdata <= '0;
        endcase
      end
    end else if (cmd.pop && status.hit) begin
      res_taken      <= 1'b1;
      res_kind       <= rd_entry.kind;
      res_origin     <= rd_entry.origin;
      res_stamp      <= rd_entry.stamp;
      res_have_stamp <= 1'b1;
    end
  end

  assign result.taken        = res_taken;
  assign result.taken_kind   = res_kind;
  assign result.taken_origin = res_origin;
  assign result.taken_stamp  = res_have_stamp ? res_stamp : cycle_counter;
  assign result.read_data    = res_rdata;
  assign result.any_pending  = gates && (queue_count != '0);
  assign result.kinds_live   = gates ? kind_enables : 3'd0;
  assign result.dropped      = res_dropped;

  `ASSERT_ALWAYS(a_count_bound, clk, rst, queue_count <= CW'(QUEUE_DEPTH))
  `ASSERT_ALWAYS(a_head_bound, clk, rst, queue_head < HW'(QUEUE_DEPTH - 1) ||
                 queue_head == HW'(QUEUE_DEPTH - 1))
  `ASSERT_ALWAYS(a_ext_queued, clk, rst, !external_held || queue_count != '0)
  `ASSERT_PROP(a_pop_nonempty, clk, rst, cmd.pop |-> queue_count != '0)

endmodule

// File: rtl/ipqc_controller.sv
`include "assert_macros.svh"

module ipqc_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ipqc_pkg::status_t status,
  output logic              busy,
  output logic              done,
  output ipqc_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state == S_EXEC) || (state == S_POP);
  assign done = state == S_RESP;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.latch = start;
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        cmd.fetch = status.take_go;
        state_next = status.take_go ? S_POP : S_RESP;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        cmd.fetch = !status.hit && status.more;
        if (status.hit || !status.more) state_next = S_RESP;
      end
      S_RESP: begin
        cmd.latch  = start;
        state_next = start ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_PROP(a_done_single, clk, rst, done |=> !done)
  `ASSERT_PROP(a_pop_origin, clk, rst, (state == S_POP) |->
               ($past(state) == S_EXEC || $past(state) == S_POP))

endmodule

// File: rtl/interrupt_pending_queue_controller.sv
// Interrupt pending-queue controller with three interrupt kinds. An item is
// accepted when start is high and busy is low; its result appears for exactly
// one cycle with done high and must be taken then, as the receiver cannot
// stall. The next item can be accepted in the cycle its result is shown. A
// take that is served pops queue entries one per cycle through the registered
// read port of the queue memory, and busy stays high while it pops.

module interrupt_pending_queue_controller #(
  parameter int QUEUE_DEPTH = ipqc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ipqc_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output ipqc_pkg::result_t  result
);

  // The sequencer decides which step runs and holds its state; the datapath holds all other state.
  ipqc_pkg::cmd_t    cmd;
  ipqc_pkg::status_t status;

  ipqc_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  // The datapath owns the queue memory, the CSRs and the cycle counter. Its
  // result fields are read from registers only, so they stay stable while
  // done is high even if a new item is being accepted in that cycle.
  ipqc_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .status  (status),
    .result  (result)
  );

endmodule
